@@ src/hta_pkg.sv @@
// hta_pkg: shared types, constants and helpers for the handle table allocator.
// Used by hta_bitmap and handle_table_allocator; depends on nothing.
package hta_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int SLOT_W     = 8;
  localparam int HANDLE_W   = 16;
  localparam int COUNT_W    = 8;
  localparam int SLOT_RANGE = (TABLE_SIZE < (1 << SLOT_W)) ? TABLE_SIZE : (1 << SLOT_W);
  localparam int SLOT_AW    = $clog2(SLOT_RANGE);
  localparam int ROW_W      = (SLOT_RANGE < 16) ? SLOT_RANGE : 16;
  localparam int BIT_W      = $clog2(ROW_W);
  localparam int ROWS       = SLOT_RANGE / ROW_W;
  localparam int ROW_AW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int NUM_PRESET = 3;
  localparam int PRE_AW     = $clog2(NUM_PRESET);

  typedef enum logic [2:0] {
    FN_OPEN      = 3'd0,
    FN_CLOSE     = 3'd1,
    FN_LOOKUP    = 3'd2,
    FN_TEST      = 3'd3,
    FN_ADD_USER  = 3'd4,
    FN_DROP_USER = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_OPEN = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // bitmap row write-back
  typedef struct packed {
    logic              en;
    logic [ROW_AW-1:0] row;
    logic [ROW_W-1:0]  data;
  } map_wr_t;

  // free-row summary
  typedef struct packed {
    logic              any_free;
    logic [ROW_AW-1:0] free_row;
  } map_stat_t;

  // bitmap row contents after reset: preset slots marked
  function automatic logic [ROW_W-1:0] map_reset_row(logic [ROW_AW-1:0] row);
    logic [ROW_W-1:0] w;
    w = '0;
    for (int b = 0; b < ROW_W; b++) begin
      if ((int'(row) * ROW_W + b) < NUM_PRESET) w[b] = 1'b1;
    end
    return w;
  endfunction

  // lowest clear bit of a bitmap row
  function automatic logic [BIT_W-1:0] row_first_free(logic [ROW_W-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (!w[b]) idx = BIT_W'(b);
    end
    return idx;
  endfunction

endpackage

@@ src/handle_table_allocator.sv @@
// handle_table_allocator: top level of the handle table with bitmap allocator.
// Uses hta_pkg and hta_bitmap; holds the host handle memory and result register.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid/in_ready, func, slot, handle   | request
//   out     | out_valid/out_ready, status .. count    | result
//
// Each beat runs in two steps: read the bitmap row and the handle memory,
// then evaluate and write back. The registered memory read sets this split.
// Reset: synchronous, active low; no clearing pass (reset rows come from
// per-row valid bits, preset handles from three flags).
// A new request is taken while a result still sits in the output register;
// the write-back cycle stalls only if that register is still full.
module handle_table_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_func,
  input  logic [hta_pkg::SLOT_W-1:0]   in_slot,
  input  logic [hta_pkg::HANDLE_W-1:0] in_host_handle,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [hta_pkg::SLOT_W-1:0]   out_slot_out,
  output logic [hta_pkg::HANDLE_W-1:0] out_host_out,
  output logic                         out_is_open,
  output logic [hta_pkg::COUNT_W-1:0]  out_user_count
);

  hta_pkg::state_t state_r, state_nxt;

  // request latched at accept
  hta_pkg::func_t               func_r;
  logic [hta_pkg::SLOT_W-1:0]   slot_r;
  logic [hta_pkg::HANDLE_W-1:0] handle_r;
  logic                         full_r;
  logic [hta_pkg::ROW_AW-1:0]   row_r;

  logic [hta_pkg::COUNT_W-1:0]  user_refs_r, user_refs_nxt;
  logic [hta_pkg::NUM_PRESET-1:0] boot_r, boot_nxt;

  // handle memory
  logic [hta_pkg::HANDLE_W-1:0] host_mem [hta_pkg::SLOT_RANGE];
  logic [hta_pkg::HANDLE_W-1:0] host_q_r;
  logic                         host_we;
  logic [hta_pkg::SLOT_AW-1:0]  host_wa;

  // bitmap
  logic                         accept;
  logic [hta_pkg::ROW_AW-1:0]   rd_row;
  logic [hta_pkg::ROW_W-1:0]    row_word;
  hta_pkg::map_wr_t             map_wr;
  hta_pkg::map_stat_t           map_stat;

  // evaluation
  logic                         out_load;
  logic                         in_range;
  logic                         marked;
  logic [hta_pkg::BIT_W-1:0]    bit_idx;
  logic [hta_pkg::BIT_W-1:0]    free_bit;
  logic [hta_pkg::SLOT_AW-1:0]  alloc_slot;
  logic                         preset_hit;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  logic [1:0]                   out_status_r, status_nxt;
  logic [hta_pkg::SLOT_W-1:0]   out_slot_r, slot_out_nxt;
  logic [hta_pkg::HANDLE_W-1:0] out_host_r, host_out_nxt;
  logic                         out_open_r, is_open_nxt;
  logic [hta_pkg::COUNT_W-1:0]  out_count_r;

  assign accept   = in_valid && in_ready;
  assign out_load = (state_r == hta_pkg::S_EXEC) && (!out_valid_r || out_ready);

  // open searches the lowest row with a free bit; the rest address their slot's row
  assign rd_row = (hta_pkg::func_t'(in_func) == hta_pkg::FN_OPEN) ? map_stat.free_row
                                                                  : in_slot[hta_pkg::BIT_W +: hta_pkg::ROW_AW];

  hta_bitmap u_bitmap (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_row  (rd_row),
    .rd_data (row_word),
    .wr      (map_wr),
    .stat    (map_stat)
  );

  always_ff @(posedge clk) begin
    if (host_we) begin
      host_mem[host_wa] <= handle_r;
    end
    if (accept) begin
      host_q_r <= host_mem[in_slot[hta_pkg::SLOT_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r   <= hta_pkg::func_t'(in_func);
      slot_r   <= in_slot;
      handle_r <= in_host_handle;
      full_r   <= !map_stat.any_free;
      row_r    <= rd_row;
    end
    if (out_load) begin
      out_status_r <= status_nxt;
      out_slot_r   <= slot_out_nxt;
      out_host_r   <= host_out_nxt;
      out_open_r   <= is_open_nxt;
      out_count_r  <= user_refs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hta_pkg::S_IDLE;
      user_refs_r <= '0;
      boot_r      <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      user_refs_r <= user_refs_nxt;
      boot_r      <= boot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hta_pkg::S_IDLE: if (accept)   state_nxt = hta_pkg::S_EXEC;
      hta_pkg::S_EXEC: if (out_load) state_nxt = hta_pkg::S_IDLE;
      default:         state_nxt = hta_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    case (state_r)
      hta_pkg::S_IDLE: in_ready = 1'b1;
      hta_pkg::S_EXEC: in_ready = 1'b0;
      default:         in_ready = 1'b0;
    endcase
  end

  // evaluate the request against the row read back
  assign in_range   = int'(slot_r) < hta_pkg::SLOT_RANGE;
  assign bit_idx    = slot_r[hta_pkg::BIT_W-1:0];
  assign marked     = in_range && row_word[bit_idx];
  assign free_bit   = hta_pkg::row_first_free(row_word);
  assign alloc_slot = {row_r, free_bit};
  assign preset_hit = (int'(slot_r) < hta_pkg::NUM_PRESET)
                      && boot_r[slot_r[hta_pkg::PRE_AW-1:0]];

  always_comb begin
    status_nxt    = hta_pkg::ST_OK;
    slot_out_nxt  = '0;
    host_out_nxt  = '0;
    is_open_nxt   = 1'b0;
    user_refs_nxt = user_refs_r;
    boot_nxt      = boot_r;
    map_wr.en     = 1'b0;
    map_wr.row    = row_r;
    map_wr.data   = row_word;
    host_we       = 1'b0;
    host_wa       = alloc_slot;
    case (func_r)
      hta_pkg::FN_OPEN: begin
        if (full_r) begin
          status_nxt = hta_pkg::ST_FULL;
        end else begin
          slot_out_nxt          = hta_pkg::SLOT_W'(alloc_slot);
          is_open_nxt           = 1'b1;
          map_wr.en             = out_load;
          map_wr.data[free_bit] = 1'b1;
          host_we               = out_load;
          // preset slot reused: the memory now holds its handle
          if ((int'(alloc_slot) < hta_pkg::NUM_PRESET) && out_load) begin
            boot_nxt[alloc_slot[hta_pkg::PRE_AW-1:0]] = 1'b0;
          end
        end
      end
      hta_pkg::FN_CLOSE: begin
        is_open_nxt = marked;
        if (marked) begin
          map_wr.en            = out_load;
          map_wr.data[bit_idx] = 1'b0;
        end else begin
          status_nxt = hta_pkg::ST_NOT_OPEN;
        end
      end
      hta_pkg::FN_LOOKUP: begin
        is_open_nxt = marked;
        if (marked) begin
          host_out_nxt = preset_hit ? hta_pkg::HANDLE_W'(slot_r) : host_q_r;
        end else begin
          status_nxt = hta_pkg::ST_NOT_OPEN;
        end
      end
      hta_pkg::FN_TEST: begin
        is_open_nxt = marked;
      end
      hta_pkg::FN_ADD_USER: begin
        if (out_load && (user_refs_r != '1)) user_refs_nxt = user_refs_r + 1'b1;
      end
      hta_pkg::FN_DROP_USER: begin
        if (out_load && (user_refs_r != '0)) user_refs_nxt = user_refs_r - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load)       out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_out   = out_slot_r;
  assign out_host_out   = out_host_r;
  assign out_is_open    = out_open_r;
  assign out_user_count = out_count_r;

`ifndef SYNTHESIS
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == hta_pkg::S_EXEC)
    else $error("request not evaluated after accept");

  a_rise_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == hta_pkg::S_EXEC))
    else $error("result appeared without evaluation");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hta_pkg::S_IDLE) |-> !map_wr.en && !host_we)
    else $error("table written outside evaluation");

  a_full_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == hta_pkg::ST_FULL) |-> out_slot_r == '0 && !out_open_r)
    else $error("table full result carries a slot");
`endif

endmodule

@@ src/hta_bitmap.sv @@
// hta_bitmap: open-slot bitmap held as a row memory with a registered read,
// per-row valid bits for reset state and a row-full summary. Uses hta_pkg.
module hta_bitmap (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [hta_pkg::ROW_AW-1:0] rd_row,
  output logic [hta_pkg::ROW_W-1:0]  rd_data,
  input  hta_pkg::map_wr_t           wr,
  output hta_pkg::map_stat_t         stat
);

  logic [hta_pkg::ROW_W-1:0]  map_mem [hta_pkg::ROWS];
  logic [hta_pkg::ROWS-1:0]   row_vld_r;
  logic [hta_pkg::ROWS-1:0]   row_full_r;
  logic [hta_pkg::ROW_W-1:0]  rd_q_r;
  logic                       rd_vld_r;
  logic [hta_pkg::ROW_AW-1:0] rd_row_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      map_mem[wr.row] <= wr.data;
    end
    if (rd_en) begin
      rd_q_r   <= map_mem[rd_row];
      rd_vld_r <= row_vld_r[rd_row];
      rd_row_r <= rd_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      for (int r = 0; r < hta_pkg::ROWS; r++) begin
        row_full_r[r] <= &hta_pkg::map_reset_row(hta_pkg::ROW_AW'(r));
      end
    end else if (wr.en) begin
      row_vld_r[wr.row]  <= 1'b1;
      row_full_r[wr.row] <= &wr.data;
    end
  end

  // rows never written read as their reset contents
  assign rd_data = rd_vld_r ? rd_q_r : hta_pkg::map_reset_row(rd_row_r);

  always_comb begin
    stat.any_free = ~&row_full_r;
    stat.free_row = '0;
    for (int r = hta_pkg::ROWS - 1; r >= 0; r--) begin
      if (!row_full_r[r]) stat.free_row = hta_pkg::ROW_AW'(r);
    end
  end

endmodule

@@ dv/hta_checker.sv @@
`timescale 1ns / 100ps
// hta_checker: watches both channels of handle_table_allocator, tracks the table
// itself, and checks every result beat in order. Depends on hta_pkg only.
module hta_checker
  import hta_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [2:0]          in_func,
  input  logic [SLOT_W-1:0]   in_slot,
  input  logic [HANDLE_W-1:0] in_host_handle,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [1:0]          out_status,
  input  logic [SLOT_W-1:0]   out_slot_out,
  input  logic [HANDLE_W-1:0] out_host_out,
  input  logic                out_is_open,
  input  logic [COUNT_W-1:0]  out_user_count,
  output int                  fail_count,
  output int                  outstanding
);

  typedef struct packed {
    logic [1:0]          status;
    logic [SLOT_W-1:0]   slot_out;
    logic [HANDLE_W-1:0] host_out;
    logic                is_open;
    logic [COUNT_W-1:0]  user_count;
  } table_reply_t;

  logic                slot_taken    [SLOT_RANGE];
  logic [HANDLE_W-1:0] stored_handle [SLOT_RANGE];
  logic [COUNT_W-1:0]  ref_count;

  table_reply_t pending_replies[$];
  int           mismatches = 0;
  int           reply_idx  = 0;

  task automatic reset_table();
    for (int i = 0; i < SLOT_RANGE; i++) begin
      slot_taken[i]    = (i < NUM_PRESET);
      stored_handle[i] = (i < NUM_PRESET) ? HANDLE_W'(i) : '0;
    end
    ref_count = '0;
  endtask

  // Applies one request to the tracked table and returns the reply it yields.
  function automatic table_reply_t compute_table_reply(input logic [2:0]          fn,
                                                       input logic [SLOT_W-1:0]   sl,
                                                       input logic [HANDLE_W-1:0] hh);
    table_reply_t r;
    logic         hit;
    int           free_idx;
    r        = '0;
    free_idx = -1;
    hit      = (int'(sl) < SLOT_RANGE) && slot_taken[sl];
    case (fn)
      FN_OPEN: begin
        for (int s = 0; s < SLOT_RANGE; s++) begin
          if (!slot_taken[s] && free_idx < 0) free_idx = s;
        end
        if (free_idx < 0) begin
          r.status = ST_FULL;
        end else begin
          slot_taken[free_idx]    = 1'b1;
          stored_handle[free_idx] = hh;
          r.slot_out              = free_idx[SLOT_W-1:0];
          r.is_open               = 1'b1;
        end
      end
      FN_CLOSE: begin
        r.is_open = hit;
        if (hit) slot_taken[sl] = 1'b0;
        else r.status = ST_NOT_OPEN;
      end
      FN_LOOKUP: begin
        r.is_open = hit;
        if (hit) r.host_out = stored_handle[sl];
        else r.status = ST_NOT_OPEN;
      end
      FN_TEST:      r.is_open = hit;
      FN_ADD_USER:  if (ref_count != '1) ref_count = ref_count + 1'b1;
      FN_DROP_USER: if (ref_count != '0) ref_count = ref_count - 1'b1;
      default: ;
    endcase
    r.user_count = ref_count;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [HANDLE_W-1:0] got,
                             input logic [HANDLE_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("reply %0d %s got 0x%0h want 0x%0h",
                                reply_idx, name, got, want));
  endtask

  always @(posedge clk) begin
    table_reply_t want;
    if (!rst_n) begin
      reset_table();
      pending_replies.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          report_mismatch($sformatf("reply %0d with no request outstanding", reply_idx));
        end else begin
          want = pending_replies.pop_front();
          check_field("status",     HANDLE_W'(out_status),     HANDLE_W'(want.status));
          check_field("slot_out",   HANDLE_W'(out_slot_out),   HANDLE_W'(want.slot_out));
          check_field("host_out",   out_host_out,              want.host_out);
          check_field("is_open",    HANDLE_W'(out_is_open),    HANDLE_W'(want.is_open));
          check_field("user_count", HANDLE_W'(out_user_count), HANDLE_W'(want.user_count));
        end
        reply_idx++;
      end
      if (in_valid && in_ready)
        pending_replies.push_back(compute_table_reply(in_func, in_slot, in_host_handle));
    end
    outstanding <= pending_replies.size();
    fail_count  <= mismatches;
  end

endmodule

@@ dv/tb_handle_table_allocator.sv @@
`timescale 1ns / 100ps
// tb_handle_table_allocator: stimulus and verdict for handle_table_allocator.
// Depends on hta_pkg, the block itself and hta_checker, which does all checking.
module tb_handle_table_allocator;
  import hta_pkg::*;

  // func codes the block must treat as no-ops
  localparam logic [2:0] FN_SPARE_6 = 3'd6;
  localparam logic [2:0] FN_SPARE_7 = 3'd7;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [2:0]          in_func = '0;
  logic [SLOT_W-1:0]   in_slot = '0;
  logic [HANDLE_W-1:0] in_host_handle = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          out_status;
  logic [SLOT_W-1:0]   out_slot_out;
  logic [HANDLE_W-1:0] out_host_out;
  logic                out_is_open;
  logic [COUNT_W-1:0]  out_user_count;

  int   fail_count;
  int   outstanding;
  logic calm = 1'b0;      // no idling on either side while set
  int   stall_left = 0;

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  handle_table_allocator u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_slot        (in_slot),
    .in_host_handle (in_host_handle),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_slot_out   (out_slot_out),
    .out_host_out   (out_host_out),
    .out_is_open    (out_is_open),
    .out_user_count (out_user_count)
  );

  hta_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_slot        (in_slot),
    .in_host_handle (in_host_handle),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_slot_out   (out_slot_out),
    .out_host_out   (out_host_out),
    .out_is_open    (out_is_open),
    .out_user_count (out_user_count),
    .fail_count     (fail_count),
    .outstanding    (outstanding)
  );

  // Result side back-pressure: random stall bursts, none while calm.
  always @(posedge clk) begin
    if (stall_left > 0 && !calm) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // One request beat. Called at a rising edge; returns at the edge that took it.
  // Valid is left high so a back-to-back beat needs only one assignment per edge;
  // an idle gap lowers it first.
  task automatic send_beat(input logic [2:0] fn, input logic [SLOT_W-1:0] sl,
                           input logic [HANDLE_W-1:0] hh);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= fn;
    in_slot        <= sl;
    in_host_handle <= hh;
    do @(posedge clk); while (!in_ready);
  endtask

  // Mostly the low slots, where opens land, so close and lookup often hit.
  function automatic logic [SLOT_W-1:0] pick_slot();
    if ($urandom_range(0, 9) < 7) return SLOT_W'($urandom_range(0, 31));
    return SLOT_W'($urandom_range(0, 255));
  endfunction

  // Random request with every func, the spare codes among them as noise.
  task automatic send_mixed_beat();
    int          r;
    logic [2:0]  fn;
    r = $urandom_range(0, 99);
    if (r < 25)      fn = FN_OPEN;
    else if (r < 45) fn = FN_CLOSE;
    else if (r < 65) fn = FN_LOOKUP;
    else if (r < 80) fn = FN_TEST;
    else if (r < 88) fn = FN_ADD_USER;
    else if (r < 96) fn = FN_DROP_USER;
    else             fn = $urandom_range(0, 1) ? FN_SPARE_6 : FN_SPARE_7;
    send_beat(fn, pick_slot(), HANDLE_W'($urandom_range(0, 65535)));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: preset slots, slot extremes, misses, reuse of a freed slot,
    // count floor, spare func codes.
    send_beat(FN_LOOKUP,    8'd0,   16'h1234);
    send_beat(FN_LOOKUP,    8'd2,   16'h0000);
    send_beat(FN_TEST,      8'd0,   16'hffff);
    send_beat(FN_TEST,      8'd255, 16'h0000);
    send_beat(FN_CLOSE,     8'd255, 16'hffff);   // closing a slot never opened
    send_beat(FN_LOOKUP,    8'd200, 16'h0000);   // lookup miss
    send_beat(FN_OPEN,      8'd255, 16'hffff);   // lands in slot 3
    send_beat(FN_OPEN,      8'd0,   16'h0000);   // slot 4
    send_beat(FN_LOOKUP,    8'd3,   16'h0000);
    send_beat(FN_LOOKUP,    8'd4,   16'hffff);
    send_beat(FN_CLOSE,     8'd1,   16'h0000);
    send_beat(FN_CLOSE,     8'd1,   16'h0000);   // double close
    send_beat(FN_TEST,      8'd1,   16'h0000);
    send_beat(FN_OPEN,      8'd77,  16'ha5a5);   // reuses slot 1
    send_beat(FN_LOOKUP,    8'd1,   16'h5a5a);
    send_beat(FN_DROP_USER, 8'd0,   16'h0000);   // count already at zero
    send_beat(FN_ADD_USER,  8'd255, 16'hffff);
    send_beat(FN_ADD_USER,  8'd0,   16'h0000);
    send_beat(FN_DROP_USER, 8'd0,   16'h0000);
    send_beat(FN_SPARE_6,   8'hff,  16'hffff);
    send_beat(FN_SPARE_7,   8'h00,  16'h0000);
    send_beat(FN_TEST,      8'd3,   16'h0000);
    send_beat(FN_CLOSE,     8'd0,   16'h0000);
    send_beat(FN_LOOKUP,    8'd0,   16'h0000);

    // Random mix over a sparse table.
    repeat (300) send_mixed_beat();

    // Fill the table past full so opens report it, with a few lookups mixed in.
    repeat (270) begin
      if ($urandom_range(0, 9) == 0)
        send_beat(FN_LOOKUP, SLOT_W'($urandom_range(0, 255)),
                  HANDLE_W'($urandom_range(0, 65535)));
      else
        send_beat(FN_OPEN, SLOT_W'($urandom_range(0, 255)),
                  HANDLE_W'($urandom_range(0, 65535)));
    end

    // Probe the full table anywhere, then punch holes in it and refill.
    repeat (100)
      send_beat($urandom_range(0, 1) ? FN_LOOKUP : FN_TEST,
                SLOT_W'($urandom_range(0, 255)), HANDLE_W'($urandom_range(0, 65535)));
    repeat (130)
      send_beat(FN_CLOSE, SLOT_W'($urandom_range(0, 255)),
                HANDLE_W'($urandom_range(0, 65535)));
    repeat (50) send_mixed_beat();

    // Hold the sender until every outstanding reply has drained.
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);

    // Drive the user count into its ceiling.
    repeat (320) begin
      if ($urandom_range(0, 11) == 0) send_mixed_beat();
      else send_beat(FN_ADD_USER, SLOT_W'($urandom_range(0, 255)),
                     HANDLE_W'($urandom_range(0, 65535)));
    end
    repeat (20) send_mixed_beat();

    // Last stretch at full rate both ways: count down to its floor.
    calm = 1'b1;
    repeat (320) begin
      if ($urandom_range(0, 11) == 0) send_mixed_beat();
      else send_beat(FN_DROP_USER, SLOT_W'($urandom_range(0, 255)),
                     HANDLE_W'($urandom_range(0, 65535)));
    end
    in_valid <= 1'b0;

    // Drain, then wait for anything unrequested to show up.
    do @(posedge clk); while (outstanding != 0);
    repeat (12) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
